// ----- src/tfn_pkg.sv -----
// Shared widths, types and constants of the triangle face normal block.
package tfn_pkg;

  localparam int POS_W     = 16;  // vertex coordinate
  localparam int U_W       = 17;  // edge vector component
  localparam int PR_W      = 34;  // edge product
  localparam int N_W       = 35;  // signed cross product component
  localparam int MG_W      = 34;  // cross product magnitude
  localparam int SQ_W      = 32;  // square of a low magnitude
  localparam int L_W       = 34;  // squared length
  localparam int LIM_W     = 32;  // degenerate limit register
  localparam int P_W       = 6;   // msb position of the magnitudes
  localparam int R_W       = 15;  // normalised magnitude
  localparam int RSQ_W     = 30;  // square of a normalised magnitude
  localparam int LP_W      = 32;  // normalised squared length
  localparam int ROOT_W    = 32;  // square root result
  localparam int SQ_REM_W  = ROOT_W + 2;
  localparam int SQ_STEPS  = 2;   // root bits resolved per stage
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
  localparam int NORM_W    = 16;  // emitted normal component
  localparam int NUM_POS   = 9;

  // Per-triangle data carried alongside the arithmetic
  typedef struct packed {
    logic [NUM_POS-1:0][POS_W-1:0] pos;
    logic [2:0]                    neg;
    logic                          degen;
    logic [2:0][R_W-1:0]           r;
  } tfn_side_t;

  // Vertex currently shown on the result channel
  typedef enum logic [1:0] {
    VTX_A,
    VTX_B,
    VTX_C
  } vtx_t;

endpackage

// ----- src/tfn_front.sv -----
// Front pipeline: edges, cross product, degenerate test and normalisation.
module tfn_front
  import tfn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [NUM_POS-1:0][POS_W-1:0] in_pos,
  input  logic [LIM_W-1:0]        limit,
  output logic                    out_valid,
  output logic [LP_W-1:0]         lp,
  output tfn_side_t               side
);

  logic [7:0] v;

  logic [NUM_POS-1:0][POS_W-1:0] p1, p2, p3, p4, p5;
  logic signed [U_W-1:0]  ux, uy, uz, vx, vy, vz;
  logic signed [PR_W-1:0] pr [6];
  logic [2:0][MG_W-1:0]   mg4, mg5;
  logic [2:0]             neg4, neg5;
  logic [2:0][SQ_W-1:0]   sq5;
  logic                   big5;
  logic [P_W-1:0]         msb5;
  tfn_side_t              s6, s7, s8;
  logic [2:0][RSQ_W-1:0]  rsq7;
  logic [LP_W-1:0]        lp8;

  logic signed [N_W-1:0]  n [3];
  logic [MG_W-1:0]        orv;
  logic [P_W-1:0]         msb;
  logic [L_W-1:0]         len2;
  logic [2:0][R_W-1:0]    r_d;
  logic [MG_W+R_W-2:0]    wide [3];

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_valid};
    end
  end

  // Cross product components
  always_comb begin
    n[0] = N_W'(pr[0]) - N_W'(pr[1]);
    n[1] = N_W'(pr[2]) - N_W'(pr[3]);
    n[2] = N_W'(pr[4]) - N_W'(pr[5]);
  end

  // Position of the leading one across all magnitudes
  always_comb begin
    orv = mg4[0] | mg4[1] | mg4[2];
    msb = '0;
    for (int b = 0; b < MG_W; b++) begin
      if (orv[b]) begin
        msb = P_W'(b);
      end
    end
  end

  // Squared length and shift of each magnitude to the normalised range
  always_comb begin
    len2 = L_W'(sq5[0]) + L_W'(sq5[1]) + L_W'(sq5[2]);
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mg5[i], {(R_W-1){1'b0}}} >> msb5;
      r_d[i]  = wide[i][R_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: hold the vertices
      p1 <= in_pos;
      // Stage 2: edge vectors
      p2 <= p1;
      ux <= U_W'($signed(p1[3])) - U_W'($signed(p1[0]));
      uy <= U_W'($signed(p1[4])) - U_W'($signed(p1[1]));
      uz <= U_W'($signed(p1[5])) - U_W'($signed(p1[2]));
      vx <= U_W'($signed(p1[6])) - U_W'($signed(p1[0]));
      vy <= U_W'($signed(p1[7])) - U_W'($signed(p1[1]));
      vz <= U_W'($signed(p1[8])) - U_W'($signed(p1[2]));
      // Stage 3: edge products
      p3 <= p2;
      pr[0] <= PR_W'(uy) * PR_W'(vz);
      pr[1] <= PR_W'(uz) * PR_W'(vy);
      pr[2] <= PR_W'(uz) * PR_W'(vx);
      pr[3] <= PR_W'(ux) * PR_W'(vz);
      pr[4] <= PR_W'(ux) * PR_W'(vy);
      pr[5] <= PR_W'(uy) * PR_W'(vx);
      // Stage 4: sign and magnitude
      p4 <= p3;
      for (int i = 0; i < 3; i++) begin
        neg4[i] <= n[i][N_W-1];
        mg4[i]  <= n[i][N_W-1] ? MG_W'(-n[i]) : n[i][MG_W-1:0];
      end
      // Stage 5: squares of small magnitudes, leading one position
      p5   <= p4;
      neg5 <= neg4;
      mg5  <= mg4;
      msb5 <= msb;
      big5 <= |orv[MG_W-1:16];
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= SQ_W'(mg4[i][15:0]) * SQ_W'(mg4[i][15:0]);
      end
      // Stage 6: degenerate decision and normalised magnitudes
      s6.pos   <= p5;
      s6.neg   <= neg5;
      s6.degen <= !big5 && (len2 <= L_W'(limit));
      s6.r     <= r_d;
      // Stage 7: squares of normalised magnitudes
      s7 <= s6;
      for (int i = 0; i < 3; i++) begin
        rsq7[i] <= RSQ_W'(s6.r[i]) * RSQ_W'(s6.r[i]);
      end
      // Stage 8: normalised squared length
      s8  <= s7;
      lp8 <= LP_W'(rsq7[0]) + LP_W'(rsq7[1]) + LP_W'(rsq7[2]);
    end
  end

  assign out_valid = v[7];
  assign lp        = lp8;
  assign side      = s8;

endmodule

// ----- src/tfn_sqrt.sv -----
// Pipelined integer square root of the normalised length shifted by 32 bits.
module tfn_sqrt
  import tfn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [LP_W-1:0]   lp,
  input  tfn_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output tfn_side_t         out_side
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   res;
    logic [LP_W-1:0]     xs;
  } sq_state_t;

  // One digit of the restoring square root, two radicand bits in
  function automatic sq_state_t sq_step(sq_state_t s);
    sq_state_t           o;
    logic [SQ_REM_W-1:0] sh;
    logic [SQ_REM_W-1:0] trial;
    sh    = {s.rem[SQ_REM_W-3:0], s.xs[LP_W-1 -: 2]};
    trial = {s.res, 2'b01};
    o.xs  = {s.xs[LP_W-3:0], 2'b00};
    if (sh >= trial) begin
      o.rem = sh - trial;
      o.res = {s.res[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = sh;
      o.res = {s.res[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  sq_state_t              st_q  [SQ_STAGES];
  sq_state_t              nxt   [SQ_STAGES];
  tfn_side_t              sd_q  [SQ_STAGES];
  logic [SQ_STAGES-1:0]   v;

  // Resolve SQ_STEPS root bits in each stage
  always_comb begin
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        nxt[s].rem = '0;
        nxt[s].res = '0;
        nxt[s].xs  = lp;
      end else begin
        nxt[s] = st_q[s-1];
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
        nxt[s] = sq_step(nxt[s]);
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[SQ_STAGES-2:0], in_valid};
    end
  end

  // Advance state and side data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        st_q[s] <= nxt[s];
        sd_q[s] <= (s == 0) ? in_side : sd_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid = v[SQ_STAGES-1];
  assign root      = st_q[SQ_STAGES-1].res;
  assign out_side  = sd_q[SQ_STAGES-1];

endmodule

// ----- src/tfn_div.sv -----
// Pipelined three-lane rounded division of the magnitudes by the length.
module tfn_div
  import tfn_pkg::*;
#(
  parameter int NF = 14
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] root,
  input  tfn_side_t         in_side,
  output logic              out_valid,
  output logic [2:0][NF:0]  quo,
  output tfn_side_t         out_side
);

  localparam int QB        = NF + 1;
  localparam int NUM_W     = R_W + NF + 17;
  localparam int DR_W      = ROOT_W + 1;
  localparam int DV_STEPS  = 2;
  localparam int DV_STAGES = (QB + DV_STEPS - 1) / DV_STEPS;

  typedef struct packed {
    logic [2:0][DR_W-1:0] rem;
    logic [2:0][QB-1:0]   ql;
  } dv_state_t;

  // One restoring quotient bit for one lane
  function automatic void dv_step(input logic [DR_W-1:0] rem_i, input logic [QB-1:0] ql_i,
                                  input logic [ROOT_W-1:0] d,
                                  output logic [DR_W-1:0] rem_o, output logic [QB-1:0] ql_o);
    logic [DR_W-1:0] sh;
    sh = {rem_i[ROOT_W-1:0], ql_i[QB-1]};
    if (sh >= DR_W'(d)) begin
      rem_o = sh - DR_W'(d);
      ql_o  = {ql_i[QB-2:0], 1'b1};
    end else begin
      rem_o = sh;
      ql_o  = {ql_i[QB-2:0], 1'b0};
    end
  endfunction

  logic [NUM_W-1:0]       num [3];
  dv_state_t              pre_q;
  logic [ROOT_W-1:0]      pre_d;
  tfn_side_t              pre_s;
  logic                   pre_v;

  dv_state_t              st_q  [DV_STAGES];
  dv_state_t              nxt   [DV_STAGES];
  logic [ROOT_W-1:0]      d_q   [DV_STAGES];
  tfn_side_t              sd_q  [DV_STAGES];
  logic [DV_STAGES-1:0]   v;

  // Numerator with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUM_W'(in_side.r[i]) << (NF + 16)) + NUM_W'(root >> 1);
    end
  end

  // Quotient bits, guarded past the last one
  always_comb begin
    for (int s = 0; s < DV_STAGES; s++) begin
      nxt[s] = (s == 0) ? pre_q : st_q[(s == 0) ? 0 : s-1];
      for (int j = 0; j < DV_STEPS; j++) begin
        if (s * DV_STEPS + j < QB) begin
          for (int i = 0; i < 3; i++) begin
            dv_step(nxt[s].rem[i], nxt[s].ql[i], (s == 0) ? pre_d : d_q[(s == 0) ? 0 : s-1],
                    nxt[s].rem[i], nxt[s].ql[i]);
          end
        end
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_v <= 1'b0;
      v     <= '0;
    end else if (en) begin
      pre_v <= in_valid;
      v     <= (DV_STAGES > 1) ? DV_STAGES'({v, pre_v}) : DV_STAGES'(pre_v);
    end
  end

  // Load the numerators, then advance the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pre_q.rem[i] <= DR_W'(num[i][NUM_W-1:QB]);
        pre_q.ql[i]  <= num[i][QB-1:0];
      end
      pre_d <= root;
      pre_s <= in_side;
      for (int s = 0; s < DV_STAGES; s++) begin
        st_q[s] <= nxt[s];
        d_q[s]  <= (s == 0) ? pre_d : d_q[(s == 0) ? 0 : s-1];
        sd_q[s] <= (s == 0) ? pre_s : sd_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid = v[DV_STAGES-1];
  assign quo       = st_q[DV_STAGES-1].ql;
  assign out_side  = sd_q[DV_STAGES-1];

endmodule

// ----- src/tfn_emit.sv -----
// Result register: applies cap, sign and fallback, then sends three vertices.
module tfn_emit
  import tfn_pkg::*;
#(
  parameter int NF = 14
)(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [2:0][NF:0]         quo,
  input  tfn_side_t                in_side,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [NORM_W-1:0] norm_x,
  output logic signed [NORM_W-1:0] norm_y,
  output logic signed [NORM_W-1:0] norm_z,
  output logic                     degenerate,
  output logic                     last_vertex
);

  localparam int         QB     = NF + 1;
  localparam logic [31:0] UNIT  = 32'd1 << NF;

  logic [2:0][NORM_W-1:0]         nrm_d;
  logic [2:0][NORM_W-1:0]         nrm_q;
  logic [NUM_POS-1:0][POS_W-1:0]  pos_q;
  logic                           deg_q;
  logic                           ov;
  vtx_t                           vtx, vtx_next;
  logic                           load;
  logic [QB-1:0]                  qc;
  logic [31:0]                    ext;
  logic [31:0]                    sgn;

  // Cap, sign and the fallback normal
  always_comb begin
    qc  = '0;
    ext = '0;
    sgn = '0;
    for (int i = 0; i < 3; i++) begin
      qc  = (quo[i] > UNIT[QB-1:0]) ? UNIT[QB-1:0] : quo[i];
      ext = 32'(qc);
      sgn = in_side.neg[i] ? (32'd0 - ext) : ext;
      if (in_side.degen) begin
        nrm_d[i] = (i == 2) ? UNIT[NORM_W-1:0] : '0;
      end else begin
        nrm_d[i] = sgn[NORM_W-1:0];
      end
    end
  end

  // Take a new triangle when empty or when the third vertex leaves
  assign take = !ov || (out_ready && vtx == VTX_C);
  assign load = in_valid && take;

  always_comb begin
    case (vtx)
      VTX_A:   vtx_next = VTX_B;
      VTX_B:   vtx_next = VTX_C;
      default: vtx_next = VTX_A;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      vtx <= VTX_A;
    end else if (load) begin
      ov  <= 1'b1;
      vtx <= VTX_A;
    end else if (ov && out_ready) begin
      ov  <= (vtx != VTX_C);
      vtx <= vtx_next;
    end
  end

  // Hold the triangle result
  always_ff @(posedge clk) begin
    if (load) begin
      nrm_q <= nrm_d;
      pos_q <= in_side.pos;
      deg_q <= in_side.degen;
    end
  end

  // Select the current vertex
  always_comb begin
    case (vtx)
      VTX_A: begin
        pos_x = $signed(pos_q[0]);
        pos_y = $signed(pos_q[1]);
        pos_z = $signed(pos_q[2]);
      end
      VTX_B: begin
        pos_x = $signed(pos_q[3]);
        pos_y = $signed(pos_q[4]);
        pos_z = $signed(pos_q[5]);
      end
      default: begin
        pos_x = $signed(pos_q[6]);
        pos_y = $signed(pos_q[7]);
        pos_z = $signed(pos_q[8]);
      end
    endcase
  end

  assign out_valid   = ov;
  assign norm_x      = $signed(nrm_q[0]);
  assign norm_y      = $signed(nrm_q[1]);
  assign norm_z      = $signed(nrm_q[2]);
  assign degenerate  = deg_q;
  assign last_vertex = (vtx == VTX_C);

endmodule

// ----- src/triangle_face_normal.sv -----
// Top level of the triangle face normal block.
// One triangle per input transfer gives three result transfers (vertex a, b, c), each with
// the vertex, the shared unit normal in Q1.NORMAL_FRAC_BITS, a degenerate flag and a last
// flag on vertex c. The input side takes a triangle every cycle while the pipeline can
// advance; the sustained rate is set by the single result channel, which sends the three
// vertices of each triangle in turn. From input transfer to first result a triangle
// passes eight front stages, sixteen square root stages at two bits each, one divider load
// stage, the divider stages at two quotient bits each, and the result register. A stalled
// result holds the whole pipeline without loss. Write degenerate_limit only while the
// block is idle.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = 14
)(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [LIM_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [POS_W-1:0]  vert_a_x,
  input  logic signed [POS_W-1:0]  vert_a_y,
  input  logic signed [POS_W-1:0]  vert_a_z,
  input  logic signed [POS_W-1:0]  vert_b_x,
  input  logic signed [POS_W-1:0]  vert_b_y,
  input  logic signed [POS_W-1:0]  vert_b_z,
  input  logic signed [POS_W-1:0]  vert_c_x,
  input  logic signed [POS_W-1:0]  vert_c_y,
  input  logic signed [POS_W-1:0]  vert_c_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [NORM_W-1:0] norm_x,
  output logic signed [NORM_W-1:0] norm_y,
  output logic signed [NORM_W-1:0] norm_z,
  output logic                     degenerate,
  output logic                     last_vertex
);

  localparam logic [LIM_W-1:0]  LIMIT_RESET = 32'd256;
  localparam logic [31:0]       UNIT        = 32'd1 << NORMAL_FRAC_BITS;

  logic [LIM_W-1:0]               limit;
  logic                           en;
  logic                           take;
  logic [NUM_POS-1:0][POS_W-1:0]  in_pos;
  logic                           fr_valid, sq_valid, dv_valid;
  logic [LP_W-1:0]                lp;
  logic [ROOT_W-1:0]              root;
  logic [2:0][NORMAL_FRAC_BITS:0] quo;
  tfn_side_t                      fr_side, sq_side, dv_side;

  // Degenerate limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // Advance the pipeline unless a finished triangle waits for the emitter
  assign en       = !dv_valid || take;
  assign in_ready = en;

  assign in_pos = {vert_c_z, vert_c_y, vert_c_x,
                   vert_b_z, vert_b_y, vert_b_x,
                   vert_a_z, vert_a_y, vert_a_x};

  tfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_pos    (in_pos),
    .limit     (limit),
    .out_valid (fr_valid),
    .lp        (lp),
    .side      (fr_side)
  );

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .lp        (lp),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (sq_side)
  );

  tfn_div #(
    .NF (NORMAL_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .root      (root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .quo       (quo),
    .out_side  (dv_side)
  );

  tfn_emit #(
    .NF (NORMAL_FRAC_BITS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dv_valid),
    .quo         (quo),
    .in_side     (dv_side),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .norm_x      (norm_x),
    .norm_y      (norm_y),
    .norm_z      (norm_z),
    .degenerate  (degenerate),
    .last_vertex (last_vertex)
  );

  // A degenerate triangle carries the fallback normal
  a_degen_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      norm_x == '0 && norm_y == '0 && norm_z == UNIT[NORM_W-1:0])
    else $error("degenerate result without fallback normal");

  // The vertices of one triangle follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_vertex |=> out_valid)
    else $error("result gap inside a triangle");

  // An empty emitter never holds back the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// ----- tb/sv/tb_triangle_face_normal.sv -----
// Self-checking testbench of the triangle face normal block.
module tb_triangle_face_normal;
  import tfn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAC     = 14;
  localparam int LIMIT_CYC = 400000;
  localparam int LAT_CYC   = 60;

  typedef struct {
    logic signed [POS_W-1:0] c [9];
  } tri_t;

  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic [NORM_W-1:0]       nx, ny, nz;
    logic                    degen;
    logic                    last;
  } vtx_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [LIM_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [POS_W-1:0] coord [9];
  logic out_valid;
  logic out_ready = 0;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
  logic degenerate, last_vertex;

  tri_t     tri_q [$];
  vtx_res_t vertex_q [$];
  logic [31:0] limit_reg = 32'd256;
  int in_idle_pct = 8, out_idle_pct = 78;
  int mismatches = 0;
  int cycles = 0;
  bit driver_busy = 0;

  initial foreach (coord[i]) coord[i] = '0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  triangle_face_normal DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .vert_a_x(coord[0]), .vert_a_y(coord[1]), .vert_a_z(coord[2]),
    .vert_b_x(coord[3]), .vert_b_y(coord[4]), .vert_b_z(coord[5]),
    .vert_c_x(coord[6]), .vert_c_y(coord[7]), .vert_c_z(coord[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate), .last_vertex(last_vertex)
  );

  // Integer square root, bit by bit
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Work out the three vertex results of one triangle
  task automatic predict_vertices(input tri_t t);
    logic signed [63:0] p [9];
    logic signed [63:0] n [3];
    logic [63:0] mg [3], r [3], nv [3];
    logic [63:0] m, len2, lp, d, q;
    logic degen;
    int rs, ls;
    vtx_res_t v;
    foreach (p[i]) p[i] = 64'(t.c[i]);
    n[0] = (p[4]-p[1])*(p[8]-p[2]) - (p[5]-p[2])*(p[7]-p[1]);
    n[1] = (p[5]-p[2])*(p[6]-p[0]) - (p[3]-p[0])*(p[8]-p[2]);
    n[2] = (p[3]-p[0])*(p[7]-p[1]) - (p[4]-p[1])*(p[6]-p[0]);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = n[i] < 0 ? -n[i] : n[i];
      if (mg[i] > m) m = mg[i];
    end
    if (m >= 64'd65536) begin
      degen = 0;
    end else begin
      len2 = mg[0]*mg[0] + mg[1]*mg[1] + mg[2]*mg[2];
      degen = len2 <= {32'd0, limit_reg};
    end
    if (degen) begin
      nv[0] = 0; nv[1] = 0; nv[2] = 64'd1 << NFRAC;
    end else begin
      rs = 0; ls = 0;
      while ((m >> rs) >= 64'd32768) rs++;
      while ((m << ls) < 64'd16384) ls++;
      for (int i = 0; i < 3; i++) r[i] = (mg[i] >> rs) << ls;
      lp = r[0]*r[0] + r[1]*r[1] + r[2]*r[2];
      d = int_sqrt(lp << 32);
      for (int i = 0; i < 3; i++) begin
        q = ((r[i] << (NFRAC + 16)) + (d >> 1)) / d;
        if (q > (64'd1 << NFRAC)) q = 64'd1 << NFRAC;
        nv[i] = n[i] < 0 ? -q : q;
      end
    end
    for (int k = 0; k < 3; k++) begin
      v.px = t.c[3*k]; v.py = t.c[3*k+1]; v.pz = t.c[3*k+2];
      v.nx = nv[0][15:0]; v.ny = nv[1][15:0]; v.nz = nv[2][15:0];
      v.degen = degen;
      v.last = (k == 2);
      vertex_q.push_back(v);
    end
  endtask

  // Drive pending triangles; predict on each transfer
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      tri_t t;
      foreach (t.c[i]) t.c[i] = coord[i];
      predict_vertices(t);
    end
    if (!rst && (!in_valid || in_ready)) begin
      if (tri_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        tri_t t;
        t = tri_q.pop_front();
        foreach (coord[i]) coord[i] <= t.c[i];
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
    driver_busy <= (tri_q.size() > 0) || (in_valid && !in_ready);
    out_ready <= !rst && ($urandom_range(99) >= out_idle_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      vtx_res_t e;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = vertex_q.pop_front();
        if (pos_x !== e.px || pos_y !== e.py || pos_z !== e.pz ||
            norm_x !== e.nx || norm_y !== e.ny || norm_z !== e.nz ||
            degenerate !== e.degen || last_vertex !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp pos %0d %0d %0d n %h %h %h d%b l%b,",
                      " got %0d %0d %0d n %h %h %h d%b l%b"},
                     e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.degen, e.last,
                     pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, degenerate, last_vertex);
        end
      end
    end
  end

  // Fail and finish on a timeout
  always @(posedge clk) begin
    if (cycles > LIMIT_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic tri_t make_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.c[0] = POS_W'(a0); t.c[1] = POS_W'(a1); t.c[2] = POS_W'(a2);
    t.c[3] = POS_W'(b0); t.c[4] = POS_W'(b1); t.c[5] = POS_W'(b2);
    t.c[6] = POS_W'(c0); t.c[7] = POS_W'(c1); t.c[8] = POS_W'(c2);
    return t;
  endfunction

  // Random triangle: mostly small edges around a random base, some full range
  function automatic tri_t rand_tri();
    tri_t t;
    int base, span, sel;
    sel = $urandom_range(9);
    if (sel < 3) begin
      foreach (t.c[i]) t.c[i] = POS_W'($urandom());
    end else begin
      span = 1 << $urandom_range(12, 1);
      for (int j = 0; j < 3; j++) begin
        base = $urandom_range(65535) - 32768;
        t.c[j] = POS_W'(base);
        t.c[j+3] = POS_W'(base + $urandom_range(2*span) - span);
        t.c[j+6] = (sel == 3) ? POS_W'(2*(t.c[j+3]) - base)
                              : POS_W'(base + $urandom_range(2*span) - span);
      end
    end
    return t;
  endfunction

  task automatic write_limit(input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    limit_reg = val;
  endtask

  task automatic drain();
    int w;
    w = 0;
    while (driver_busy || tri_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
    while (w < LAT_CYC) begin
      @(posedge clk);
      w++;
    end
  endtask

  initial begin
    logic [31:0] limits [5] = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'd4096, 32'd256};
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: extremes, zero area, axis normals, near-limit areas
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_q.push_back(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    tri_q.push_back(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 4096, 4096, 0, 0));
    tri_q.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767));
    tri_q.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768));
    tri_q.push_back(make_tri(0, 0, 0, 16, 0, 0, 0, 16, 0));
    tri_q.push_back(make_tri(0, 0, 0, 16, 0, 0, 0, 17, 0));
    tri_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    tri_q.push_back(make_tri(5, 5, 5, 10, 10, 10, 20, 20, 20));
    tri_q.push_back(make_tri(0, 0, 0, 255, 0, 0, 0, 256, 0));
    tri_q.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    tri_q.push_back(make_tri(-1, -1, -1, 32767, -1, 3, 7, 32767, -32768));
    tri_q.push_back(make_tri(100, -200, 300, -400, 500, -600, 700, -800, 901));
    tri_q.push_back(make_tri(0, 0, 0, 3, 1, 2, 1, 3, 2));
    tri_q.push_back(make_tri(-21846, 21845, -21846, 21845, -21846, 21845, 1, 2, 3));
    drain();

    // Random phases over several limits and idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      in_idle_pct = (ph < 2) ? 8 : (ph < 4 ? 78 : 0);
      out_idle_pct = (ph < 2) ? 78 : (ph < 4 ? 8 : 0);
      for (int i = 0; i < 70; i++) tri_q.push_back(rand_tri());
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
